// ----- sv/crg_pkg.sv -----
// Shared types, register indexes and address window checks for the runaway guard.
`default_nettype none

package crg_pkg;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_GUARD_ENABLE    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_TRIGGER_SAMPLES = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_HOLD_TICKS      = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_COOLDOWN_TICKS  = 2'd3;

  localparam logic        GUARD_ENABLE_RESET    = 1'b1;
  localparam logic [7:0]  TRIGGER_SAMPLES_RESET = 8'd3;
  localparam logic [15:0] HOLD_TICKS_RESET      = 16'd50;
  localparam logic [15:0] COOLDOWN_TICKS_RESET  = 16'd300;

  localparam logic [7:0] STREAK_MAX = 8'hFF;

  // Valid code windows
  localparam logic [31:0] LOW_END     = 32'h0000_4000;
  localparam logic [31:0] WIN_A_START = 32'h0200_0000;
  localparam logic [31:0] WIN_A_END   = 32'h0203_FFFF;
  localparam logic [31:0] WIN_B_START = 32'h0300_0000;
  localparam logic [31:0] WIN_B_END   = 32'h0300_7FFF;
  localparam logic [31:0] WIN_C_START = 32'h0800_0000;
  localparam logic [31:0] WIN_C_END   = 32'h0DFF_FFFF;

  typedef struct packed {
    logic        guard_enable;
    logic [7:0]  trigger_samples;
    logic [15:0] hold_ticks;
    logic [15:0] cooldown_ticks;
  } crg_cfg_t;

  typedef struct packed {
    logic        rom_ready;
    logic [31:0] pc_first;
    logic [31:0] pc_retry_one;
    logic [31:0] pc_retry_two;
    logic [31:0] mem_state_word;
    logic        audio_muted;
    logic        audio_audible;
  } crg_item_t;

  typedef struct packed {
    logic [15:0] cooldown_left;
    logic [15:0] hold_left;
    logic        recovering;
    logic [7:0]  invalid_streak;
    logic        restore_pending;
    logic [31:0] recovery_total;
    logic [31:0] last_bad_pc;
    logic [31:0] last_bad_mem;
  } crg_state_t;

  typedef struct packed {
    logic        halt_and_reset;
    logic        release_reset;
    logic        mute_request;
    logic        unmute_request;
    logic        recovery_active;
    logic [7:0]  streak_count;
    logic [31:0] trigger_total;
    logic [31:0] bad_pc;
    logic [31:0] bad_mem;
  } crg_result_t;

  function automatic logic addr_ok(input logic [31:0] a);
    logic ok;
    ok = (a < LOW_END)
      || (a >= WIN_A_START && a <= WIN_A_END)
      || (a >= WIN_B_START && a <= WIN_B_END)
      || (a >= WIN_C_START && a <= WIN_C_END);
    return ok;
  endfunction

endpackage

`default_nettype wire

// ----- sv/crg_eval.sv -----
// Per-tick evaluation: window checks, streak, trigger, hold and audio decisions.
`default_nettype none

module crg_eval
  import crg_pkg::*;
(
  input  crg_cfg_t    cfg,
  input  crg_state_t  state,
  input  crg_item_t   item,
  output crg_state_t  state_next,
  output crg_result_t result
);

  logic        halt;
  logic        rel;
  logic        mute;
  logic        unmute;
  logic [15:0] cd;
  logic [15:0] hold_dec;
  logic [7:0]  streak_inc;
  logic        ok_first;
  logic        unconfirmed;

  assign ok_first    = addr_ok(item.pc_first);
  assign unconfirmed = addr_ok(item.pc_retry_one) || addr_ok(item.pc_retry_two)
                    || (item.mem_state_word[31:24] == 8'd0);
  assign cd          = (state.cooldown_left != 16'd0) ? state.cooldown_left - 16'd1 : 16'd0;
  assign hold_dec    = (state.hold_left != 16'd0) ? state.hold_left - 16'd1 : 16'd0;
  assign streak_inc  = (state.invalid_streak < STREAK_MAX) ? state.invalid_streak + 8'd1
                                                           : state.invalid_streak;

  always_comb begin
    state_next = state;
    halt       = 1'b0;
    rel        = 1'b0;
    mute       = 1'b0;
    unmute     = 1'b0;
    if (!item.rom_ready) begin
      state_next.invalid_streak = 8'd0;
    end else begin
      state_next.cooldown_left = cd;
      if (!cfg.guard_enable) begin
        if (state.recovering) begin
          rel                   = 1'b1;
          state_next.recovering = 1'b0;
          state_next.hold_left  = 16'd0;
        end
        if (state.restore_pending && item.audio_muted) begin
          unmute                     = 1'b1;
          state_next.restore_pending = 1'b0;
        end
        state_next.invalid_streak = 8'd0;
      end else if (state.recovering) begin
        state_next.hold_left = hold_dec;
        if (hold_dec == 16'd0) begin
          rel                       = 1'b1;
          state_next.recovering     = 1'b0;
          state_next.invalid_streak = 8'd0;
        end
      end else if (ok_first) begin
        state_next.invalid_streak = 8'd0;
        if (state.restore_pending && cd == 16'd0 && item.audio_muted) begin
          unmute                     = 1'b1;
          state_next.restore_pending = 1'b0;
        end
      end else if (unconfirmed) begin
        state_next.invalid_streak = 8'd0;
      end else begin
        state_next.last_bad_pc  = item.pc_retry_two;
        state_next.last_bad_mem = item.mem_state_word;
        if (cd == 16'd0) begin
          state_next.invalid_streak = streak_inc;
          if (streak_inc >= cfg.trigger_samples) begin
            halt                      = 1'b1;
            state_next.recovery_total = state.recovery_total + 32'd1;
            state_next.recovering     = 1'b1;
            state_next.hold_left      = cfg.hold_ticks;
            state_next.cooldown_left  = cfg.cooldown_ticks;
            state_next.invalid_streak = 8'd0;
            // mute only audio that is actually playing
            if (!item.audio_muted && item.audio_audible) begin
              mute                       = 1'b1;
              state_next.restore_pending = 1'b1;
            end else begin
              state_next.restore_pending = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    result.halt_and_reset  = halt;
    result.release_reset   = rel;
    result.mute_request    = mute;
    result.unmute_request  = unmute;
    result.recovery_active = state_next.recovering;
    result.streak_count    = state_next.invalid_streak;
    result.trigger_total   = state_next.recovery_total;
    result.bad_pc          = state_next.last_bad_pc;
    result.bad_mem         = state_next.last_bad_mem;
  end

endmodule

`default_nettype wire

// ----- sv/cpu_runaway_guard.sv -----
// Top level of the CPU runaway guard: input register, tick evaluation, result register.
//
// One monitor tick is one transaction on the input channel; each tick yields exactly one
// result transaction. Ticks stream at one per clock: a tick is captured in the input
// register, is evaluated against the guard state on its way into the result register, and
// is shown on the output from there. The guard state (streak, hold and cooldown counters,
// audio restore flag, snapshots) updates in that same step, so each tick sees everything
// earlier ticks left. Throughput drops only while the output stalls. Configuration writes
// take effect on the next evaluated tick; write only when idle.
`default_nettype none

module cpu_runaway_guard
  import crg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,

  input  wire logic                     cfg_write,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data,

  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     rom_ready,
  input  wire logic [31:0]              pc_first,
  input  wire logic [31:0]              pc_retry_one,
  input  wire logic [31:0]              pc_retry_two,
  input  wire logic [31:0]              mem_state_word,
  input  wire logic                     audio_muted,
  input  wire logic                     audio_audible,

  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          halt_and_reset,
  output logic                          release_reset,
  output logic                          mute_request,
  output logic                          unmute_request,
  output logic                          recovery_active,
  output logic [7:0]                    streak_count,
  output logic [31:0]                   trigger_total,
  output logic [31:0]                   bad_pc,
  output logic [31:0]                   bad_mem
);

  crg_cfg_t    cfg;
  crg_state_t  state;
  crg_state_t  state_next;
  crg_item_t   item;
  crg_item_t   item_in;
  logic        item_valid;
  crg_result_t result;
  crg_result_t result_next;
  logic        out_free;
  logic        advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  assign item_in = '{rom_ready:      rom_ready,
                     pc_first:       pc_first,
                     pc_retry_one:   pc_retry_one,
                     pc_retry_two:   pc_retry_two,
                     mem_state_word: mem_state_word,
                     audio_muted:    audio_muted,
                     audio_audible:  audio_audible};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.guard_enable    <= GUARD_ENABLE_RESET;
      cfg.trigger_samples <= TRIGGER_SAMPLES_RESET;
      cfg.hold_ticks      <= HOLD_TICKS_RESET;
      cfg.cooldown_ticks  <= COOLDOWN_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GUARD_ENABLE:    cfg.guard_enable    <= cfg_data[0];
        REG_TRIGGER_SAMPLES: cfg.trigger_samples <= cfg_data[7:0];
        REG_HOLD_TICKS:      cfg.hold_ticks      <= cfg_data;
        REG_COOLDOWN_TICKS:  cfg.cooldown_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register: load whenever it is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= item_in;
    end
  end

  crg_eval u_eval (
    .cfg        (cfg),
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign halt_and_reset  = result.halt_and_reset;
  assign release_reset   = result.release_reset;
  assign mute_request    = result.mute_request;
  assign unmute_request  = result.unmute_request;
  assign recovery_active = result.recovery_active;
  assign streak_count    = result.streak_count;
  assign trigger_total   = result.trigger_total;
  assign bad_pc          = result.bad_pc;
  assign bad_mem         = result.bad_mem;

endmodule

`default_nettype wire

// ----- sv/crg_checker.sv -----
// Port-level checker for the runaway guard and its bind to the top level.
`default_nettype none

module crg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        halt_and_reset,
  input wire logic        release_reset,
  input wire logic        mute_request,
  input wire logic        unmute_request,
  input wire logic        recovery_active,
  input wire logic [7:0]  streak_count,
  input wire logic [31:0] trigger_total
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(trigger_total) && $stable(streak_count)
      && $stable(halt_and_reset))
    else $error("stalled result changed");

  // a trigger enters recovery with the streak cleared
  a_halt_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && halt_and_reset |-> recovery_active && streak_count == 8'd0)
    else $error("trigger without recovery state");

  // a release leaves recovery with the streak cleared
  a_release_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_reset |-> !recovery_active && streak_count == 8'd0)
    else $error("release left recovery active");

  // mute only comes with a trigger, and never with an unmute or a release
  a_mute_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && mute_request |-> halt_and_reset && !unmute_request && !release_reset)
    else $error("mute request without trigger");

endmodule

bind cpu_runaway_guard crg_checker u_crg_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the CPU runaway guard: directed and random ticks checked against a tick model.

module tb_top;
  import crg_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;

  logic                     clk            = 1'b0;
  logic                     rst            = 1'b1;
  logic                     cfg_write      = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index      = '0;
  logic [CfgDataWidth-1:0]  cfg_data       = '0;
  logic                     in_valid       = 1'b0;
  logic                     rom_ready      = 1'b0;
  logic [31:0]              pc_first       = '0;
  logic [31:0]              pc_retry_one   = '0;
  logic [31:0]              pc_retry_two   = '0;
  logic [31:0]              mem_state_word = '0;
  logic                     audio_muted    = 1'b0;
  logic                     audio_audible  = 1'b0;
  logic                     out_stall      = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic        halt_and_reset;
  logic        release_reset;
  logic        mute_request;
  logic        unmute_request;
  logic        recovery_active;
  logic [7:0]  streak_count;
  logic [31:0] trigger_total;
  logic [31:0] bad_pc;
  logic [31:0] bad_mem;

  cpu_runaway_guard dut (.*);

  crg_cfg_t    guard_cfg;
  crg_state_t  guard_st;
  crg_result_t guard_verdicts[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned ticks_sent    = 0;
  int unsigned fault_count   = 0;
  int unsigned cycle_count   = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tick model

  function automatic logic pc_in_code(input logic [31:0] a);
    return (a < LOW_END) || (a inside {[WIN_A_START:WIN_A_END], [WIN_B_START:WIN_B_END],
                                       [WIN_C_START:WIN_C_END]});
  endfunction

  function automatic void drop_recovery();
    guard_st.recovering     = 1'b0;
    guard_st.hold_left      = '0;
    guard_st.invalid_streak = '0;
  endfunction

  function automatic crg_result_t evaluate_tick(input crg_item_t t);
    crg_result_t r;
    r = '0;
    if (!t.rom_ready) begin
      guard_st.invalid_streak = '0;
    end else begin
      if (guard_st.cooldown_left != 0) guard_st.cooldown_left = guard_st.cooldown_left - 16'd1;
      if (!guard_cfg.guard_enable) begin
        if (guard_st.recovering) begin
          r.release_reset = 1'b1;
          drop_recovery();
        end
        if (guard_st.restore_pending && t.audio_muted) begin
          r.unmute_request         = 1'b1;
          guard_st.restore_pending = 1'b0;
        end
        guard_st.invalid_streak = '0;
      end else if (guard_st.recovering) begin
        if (guard_st.hold_left != 0) guard_st.hold_left = guard_st.hold_left - 16'd1;
        if (guard_st.hold_left == 0) begin
          r.release_reset = 1'b1;
          drop_recovery();
        end
      end else if (pc_in_code(t.pc_first)) begin
        guard_st.invalid_streak = '0;
        if (guard_st.restore_pending && guard_st.cooldown_left == 0 && t.audio_muted) begin
          r.unmute_request         = 1'b1;
          guard_st.restore_pending = 1'b0;
        end
      end else if (pc_in_code(t.pc_retry_one) || pc_in_code(t.pc_retry_two)
                   || t.mem_state_word[31:24] == 8'd0) begin
        guard_st.invalid_streak = '0;
      end else begin
        guard_st.last_bad_pc  = t.pc_retry_two;
        guard_st.last_bad_mem = t.mem_state_word;
        if (guard_st.cooldown_left == 0) begin
          if (guard_st.invalid_streak != STREAK_MAX)
            guard_st.invalid_streak = guard_st.invalid_streak + 8'd1;
          if (guard_st.invalid_streak >= guard_cfg.trigger_samples) begin
            guard_st.recovery_total  = guard_st.recovery_total + 32'd1;
            guard_st.recovering      = 1'b1;
            guard_st.hold_left       = guard_cfg.hold_ticks;
            guard_st.cooldown_left   = guard_cfg.cooldown_ticks;
            guard_st.invalid_streak  = '0;
            r.mute_request           = !t.audio_muted && t.audio_audible;
            guard_st.restore_pending = r.mute_request;
            r.halt_and_reset         = 1'b1;
          end
        end
      end
    end
    r.recovery_active = guard_st.recovering;
    r.streak_count    = guard_st.invalid_streak;
    r.trigger_total   = guard_st.recovery_total;
    r.bad_pc          = guard_st.last_bad_pc;
    r.bad_mem         = guard_st.last_bad_mem;
    return r;
  endfunction

  // ---------------------------------------------------------------- result check

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      fault_count++;
      if (fault_count <= 10)
        $display("[%0t] %s mismatch: expected %h, actual %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    crg_result_t got;
    crg_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {halt_and_reset, release_reset, mute_request, unmute_request, recovery_active,
             streak_count, trigger_total, bad_pc, bad_mem};
      if (guard_verdicts.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("[%0t] result with none expected: %h", $realtime, got);
      end else begin
        want = guard_verdicts.pop_front();
        compare_field("halt_and_reset", 32'(want.halt_and_reset), 32'(got.halt_and_reset));
        compare_field("release_reset", 32'(want.release_reset), 32'(got.release_reset));
        compare_field("mute_request", 32'(want.mute_request), 32'(got.mute_request));
        compare_field("unmute_request", 32'(want.unmute_request), 32'(got.unmute_request));
        compare_field("recovery_active", 32'(want.recovery_active),
                      32'(got.recovery_active));
        compare_field("streak_count", 32'(want.streak_count), 32'(got.streak_count));
        compare_field("trigger_total", want.trigger_total, got.trigger_total);
        compare_field("bad_pc", want.bad_pc, got.bad_pc);
        compare_field("bad_mem", want.bad_mem, got.bad_mem);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_tick(input crg_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    rom_ready      <= t.rom_ready;
    pc_first       <= t.pc_first;
    pc_retry_one   <= t.pc_retry_one;
    pc_retry_two   <= t.pc_retry_two;
    mem_state_word <= t.mem_state_word;
    audio_muted    <= t.audio_muted;
    audio_audible  <= t.audio_audible;
    do @(posedge clk); while (in_stall);
    guard_verdicts.push_back(evaluate_tick(t));
    ticks_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (guard_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_GUARD_ENABLE:    guard_cfg.guard_enable    = data[0];
      REG_TRIGGER_SAMPLES: guard_cfg.trigger_samples = data[7:0];
      REG_HOLD_TICKS:      guard_cfg.hold_ticks      = data;
      REG_COOLDOWN_TICKS:  guard_cfg.cooldown_ticks  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tick builders

  function automatic crg_item_t make_tick(input logic ready, input logic [31:0] p0,
                                          input logic [31:0] p1, input logic [31:0] p2,
                                          input logic [31:0] mem, input logic muted,
                                          input logic audible);
    crg_item_t t;
    t.rom_ready      = ready;
    t.pc_first       = p0;
    t.pc_retry_one   = p1;
    t.pc_retry_two   = p2;
    t.mem_state_word = mem;
    t.audio_muted    = muted;
    t.audio_audible  = audible;
    return t;
  endfunction

  function automatic logic [31:0] code_pc();
    case ($urandom_range(4))
      0: return $urandom_range(LOW_END - 1, 0);
      1: return $urandom_range(WIN_A_END, WIN_A_START);
      2: return $urandom_range(WIN_B_END, WIN_B_START);
      3: return $urandom_range(WIN_C_END, WIN_C_START);
      default:
        case ($urandom_range(7))
          0: return LOW_END - 1;
          1: return WIN_A_START;
          2: return WIN_A_END;
          3: return WIN_B_START;
          4: return WIN_B_END;
          5: return WIN_C_START;
          6: return WIN_C_END;
          default: return 32'h0;
        endcase
    endcase
  endfunction

  function automatic logic [31:0] wild_pc();
    case ($urandom_range(5))
      0: return $urandom_range(WIN_A_START - 1, LOW_END);
      1: return $urandom_range(WIN_B_START - 1, WIN_A_END + 1);
      2: return $urandom_range(WIN_C_START - 1, WIN_B_END + 1);
      3: return $urandom_range(32'hFFFF_FFFF, WIN_C_END + 1);
      4: return $urandom() | 32'h1000_0000;
      default:
        case ($urandom_range(7))
          0: return LOW_END;
          1: return WIN_A_START - 1;
          2: return WIN_A_END + 1;
          3: return WIN_B_START - 1;
          4: return WIN_B_END + 1;
          5: return WIN_C_START - 1;
          6: return WIN_C_END + 1;
          default: return 32'hFFFF_FFFF;
        endcase
    endcase
  endfunction

  function automatic logic [31:0] busy_mem();
    return {8'($urandom_range(255, 1)), 24'($urandom())};
  endfunction

  function automatic crg_item_t runaway_tick(input logic muted, input logic audible);
    return make_tick(1'b1, wild_pc(), wild_pc(), wild_pc(), busy_mem(), muted, audible);
  endfunction

  function automatic crg_item_t code_tick(input logic muted, input logic audible);
    return make_tick(1'b1, code_pc(), $urandom(), $urandom(), $urandom(), muted, audible);
  endfunction

  // one escape route is left open, so the runaway is not confirmed
  function automatic crg_item_t unconfirmed_tick();
    crg_item_t t;
    t = runaway_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    case ($urandom_range(2))
      0: t.pc_retry_one = code_pc();
      1: t.pc_retry_two = code_pc();
      default: t.mem_state_word[31:24] = 8'd0;
    endcase
    return t;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_window_edges();
    send_tick(make_tick(1'b1, 32'h0, $urandom(), $urandom(), 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_tick(make_tick(1'b1, LOW_END - 1, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
    send_tick(make_tick(1'b1, LOW_END, WIN_A_START - 1, WIN_B_END + 1, 32'h0100_0000,
                        1'b0, 1'b0));
    send_tick(make_tick(1'b1, WIN_A_END + 1, WIN_A_END, 32'hFFFF_FFFF, 32'hFF00_0000,
                        1'b0, 1'b0));
    send_tick(make_tick(1'b1, WIN_B_START - 1, WIN_C_START - 1, WIN_C_END + 1,
                        32'h00FF_FFFF, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 32'hFFFF_FFFF, WIN_C_END + 1, WIN_B_START, 32'hFFFF_FFFF,
                        1'b0, 1'b0));
    send_tick(runaway_tick(1'b0, 1'b0));
    // not ready: streak clears, everything else freezes
    send_tick(make_tick(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        1'b1, 1'b1));
    send_tick(make_tick(1'b1, WIN_A_START, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, WIN_B_END, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, WIN_C_START, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, WIN_C_END, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
  endtask

  task automatic test_trigger_release();
    wait_idle();
    write_reg(REG_HOLD_TICKS, 16'd0);
    write_reg(REG_COOLDOWN_TICKS, 16'd3);
    send_tick(runaway_tick(1'b0, 1'b0));
    send_tick(runaway_tick(1'b0, 1'b0));
    send_tick(runaway_tick(1'b0, 1'b1));
    // zero hold releases on the next enabled tick
    send_tick(code_tick(1'b1, 1'b1));
    send_tick(runaway_tick(1'b0, 1'b1));
    repeat (3) send_tick(code_tick(1'b1, 1'b0));
    // high byte is masked off, leaving a zero trigger count
    wait_idle();
    write_reg(REG_TRIGGER_SAMPLES, 16'h0100);
    send_tick(runaway_tick(1'b1, 1'b1));
  endtask

  task automatic test_guard_disable();
    wait_idle();
    write_reg(REG_TRIGGER_SAMPLES, 16'd1);
    write_reg(REG_HOLD_TICKS, 16'd40);
    write_reg(REG_COOLDOWN_TICKS, 16'd5);
    send_tick(code_tick(1'b0, 1'b0));
    send_tick(runaway_tick(1'b0, 1'b1));
    send_tick(runaway_tick(1'b0, 1'b1));
    wait_idle();
    write_reg(REG_GUARD_ENABLE, 16'hFFFE);
    send_tick(code_tick(1'b1, 1'b0));
    send_tick(runaway_tick(1'b1, 1'b1));
    wait_idle();
    write_reg(REG_GUARD_ENABLE, 16'h0001);
  endtask

  task automatic apply_random_settings();
    logic [7:0]  trig;
    logic [15:0] hold;
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0)      trig = 8'd0;
    else if (pick == 1) trig = 8'($urandom_range(255, 7));
    else                trig = 8'($urandom_range(5, 1));
    hold = ($urandom_range(15) == 0) ? 16'($urandom_range(300, 30)) : 16'($urandom_range(10, 0));
    write_reg(REG_GUARD_ENABLE, {15'($urandom()), 1'($urandom_range(9) != 0)});
    write_reg(REG_TRIGGER_SAMPLES, {8'($urandom()), trig});
    write_reg(REG_HOLD_TICKS, hold);
    write_reg(REG_COOLDOWN_TICKS, 16'($urandom_range(25, 0)));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned target;
    int unsigned seg_end;
    int unsigned run_len;
    int unsigned kind;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      wait_idle();
      apply_random_settings();
      seg_end = ticks_sent + $urandom_range(140, 60);
      while (ticks_sent < seg_end && ticks_sent < target) begin
        kind = $urandom_range(99);
        if (kind < 45) begin
          run_len = (guard_cfg.trigger_samples > 6) ? $urandom_range(8, 1)
                                                    : $urandom_range(guard_cfg.trigger_samples + 2, 1);
          repeat (run_len) send_tick(runaway_tick($urandom_range(3) == 0, $urandom_range(3) != 0));
        end else if (kind < 75) begin
          repeat ($urandom_range(6, 1))
            send_tick(code_tick($urandom_range(9) < 7, 1'($urandom_range(1))));
        end else if (kind < 87) begin
          send_tick(unconfirmed_tick());
        end else if (kind < 94) begin
          send_tick(make_tick(1'b0, $urandom(), $urandom(), $urandom(), $urandom(),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
        end else begin
          send_tick(make_tick(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                              $urandom(), 1'($urandom_range(1)), 1'($urandom_range(1))));
        end
      end
    end
  endtask

  task automatic test_extreme_settings();
    wait_idle();
    // release any leftover recovery
    write_reg(REG_GUARD_ENABLE, 16'h0000);
    send_tick(code_tick(1'b1, 1'b1));
    wait_idle();
    write_reg(REG_GUARD_ENABLE, 16'hFFFF);
    write_reg(REG_TRIGGER_SAMPLES, 16'h00FF);
    write_reg(REG_HOLD_TICKS, 16'hFFFF);
    write_reg(REG_COOLDOWN_TICKS, 16'hFFFF);
    repeat (30) send_tick(code_tick(1'b0, 1'b0));
    repeat (254) send_tick(runaway_tick(1'b0, 1'b0));
    send_tick(runaway_tick(1'b0, 1'b1));
    repeat (20) send_tick(($urandom_range(1) != 0) ? runaway_tick(1'b0, 1'b1)
                                                  : code_tick(1'b1, 1'b1));
    wait_idle();
    write_reg(REG_GUARD_ENABLE, 16'h0000);
    send_tick(code_tick(1'b1, 1'b1));
    wait_idle();
    write_reg(REG_GUARD_ENABLE, 16'h0001);
    repeat (10) send_tick(runaway_tick(1'b0, 1'b1));
  endtask

  initial begin
    guard_cfg.guard_enable    = GUARD_ENABLE_RESET;
    guard_cfg.trigger_samples = TRIGGER_SAMPLES_RESET;
    guard_cfg.hold_ticks      = HOLD_TICKS_RESET;
    guard_cfg.cooldown_ticks  = COOLDOWN_TICKS_RESET;
    guard_st = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_window_edges();
    test_trigger_release();
    test_guard_disable();

    send_idle_pct = 25;
    stall_pct     = 72;
    test_random_traffic(550);
    send_idle_pct = 72;
    stall_pct     = 25;
    test_random_traffic(550);
    send_idle_pct = 0;
    stall_pct     = 0;
    test_random_traffic(550);

    test_extreme_settings();
    wait_idle();

    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/crg_pkg.sv
sv/crg_eval.sv
sv/cpu_runaway_guard.sv
sv/crg_checker.sv
dv/tb_top.sv
